### sv/assert_macros.svh
// Shared assertion forms, clocked on i_clk and quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/swr_pkg.sv
package swr_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int WORD_W       = 31;
    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = $clog2(WORD_W);

    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] ELEMENT_COUNT_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET  = CFG_W'(64);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_MOD,
        ST_SELECT,
        ST_EMIT
    } t_state;

    // Token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic             is_select;  // 0: count free slots, 1: find ranked slot
        logic [IDX_W-1:0] idx;        // index of the cell the token enters
        logic [CNT_W-1:0] val;        // running free count, or rank still to skip
        logic             found;
        logic [IDX_W-1:0] pick;
    } t_tok;

endpackage

### sv/swr_cell.sv
module swr_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  swr_pkg::t_tok            i_tok,
    input  logic [swr_pkg::CNT_W-1:0] i_limit,
    input  logic                     i_clear,
    output swr_pkg::t_tok            o_tok
);

    logic          r_used;
    swr_pkg::t_tok r_tok;
    swr_pkg::t_tok n_tok;
    logic          w_active;
    logic          w_hit;

    // A cell takes part only if its slot is free and below the element count.
    assign w_active = i_tok.valid && !r_used
                      && ({1'b0, i_tok.idx} < i_limit);
    assign w_hit    = w_active && i_tok.is_select && !i_tok.found
                      && (i_tok.val == '0);

    always_comb begin
        n_tok     = i_tok;
        n_tok.idx = i_tok.idx + swr_pkg::IDX_W'(1);
        if (!i_tok.is_select) begin
            if (w_active) begin
                n_tok.val = i_tok.val + swr_pkg::CNT_W'(1);
            end
        end else if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.pick  = i_tok.idx;
        end else if (w_active && !i_tok.found) begin
            n_tok.val = i_tok.val - swr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_clear) begin
                r_used <= 1'b0;
            end else if (w_hit) begin
                r_used <= 1'b1;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

### sv/swr_mod.sv
module swr_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [swr_pkg::WORD_W-1:0] i_dividend,
    input  logic [swr_pkg::CNT_W-1:0]  i_divisor,
    output logic                      o_done,
    output logic [swr_pkg::IDX_W-1:0]  o_rem
);

    logic                       r_busy;
    logic                       r_done;
    logic [swr_pkg::STEP_W-1:0] r_step;
    logic [swr_pkg::WORD_W-1:0] r_quo;
    logic [swr_pkg::IDX_W-1:0]  r_rem;
    logic [swr_pkg::CNT_W-1:0]  r_div;
    logic [swr_pkg::CNT_W-1:0]  w_trial;
    logic [swr_pkg::IDX_W-1:0]  n_rem;

    // Restoring division, one dividend bit per cycle; remainder stays below divisor.
    assign w_trial = {r_rem, r_quo[swr_pkg::WORD_W-1]};

    always_comb begin
        if (w_trial >= r_div) begin
            n_rem = swr_pkg::IDX_W'(w_trial - r_div);
        end else begin
            n_rem = w_trial[swr_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[swr_pkg::WORD_W-2:0], 1'b0};
                r_rem <= n_rem;
                r_step <= r_step + swr_pkg::STEP_W'(1);
                if (r_step == swr_pkg::STEP_W'(swr_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### sv/sample_without_replacement_core.sv
// Random sampling without replacement.
// Input stream: one random word per item (tdata), with tuser set to restart
// the run before that draw. Output stream: one item per input item carrying
// the chosen element index (tdata); tlast marks the draw that completes the
// run of sample_count draws, after which the used map and draw count clear.
// Config channel: index 0 writes element_count, index 1 writes sample_count;
// write only while idle. Other indexes are ignored.
// Items are handled one at a time: a token pass down the cell chain counts
// free slots, the restoring divider works through the 31 dividend bits for
// the modulo, and a second pass finds and marks the ranked slot. The chain
// length sets both passes.
// Input ready is high only while idle; a finished result sits in the output
// register, so the next item is taken while it waits. If the receiver still
// holds the previous result when a new one is ready, the core waits.
// Reset (synchronous, active low) clears the used map, the draw count and
// all valid flags, and sets both counts to 64. No clearing pass is needed.
`include "assert_macros.svh"

module sample_without_replacement_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [31:0]                   i_s_axis_tdata,  // [30:0] random_word, [31] zero
    input  logic                          i_s_axis_tuser,  // [0] restart
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // [5:0] chosen_index, [7:6] zero
    output logic                          o_m_axis_tlast,  // run_last
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swr_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int N = swr_pkg::MAX_ELEMENTS;

    swr_pkg::t_state r_state;
    swr_pkg::t_state n_state;

    logic [swr_pkg::CFG_W-1:0]  r_elem;
    logic [swr_pkg::CFG_W-1:0]  r_samp;
    logic [swr_pkg::WORD_W-1:0] r_word;
    logic [swr_pkg::CNT_W-1:0]  r_dc;
    logic [swr_pkg::IDX_W-1:0]  r_pick;
    logic                       r_last;
    logic                       r_out_valid;
    logic [swr_pkg::IDX_W-1:0]  r_out_index;
    logic                       r_out_last;
    swr_pkg::t_tok              r_inj;
    swr_pkg::t_tok              n_inj;

    swr_pkg::t_tok              w_tok [N+1];
    swr_pkg::t_tok              w_end;
    logic [swr_pkg::CNT_W-1:0]  w_n;
    logic [swr_pkg::CNT_W-1:0]  w_s;
    logic                       w_accept;
    logic                       w_count_done;
    logic                       w_sel_done;
    logic                       w_mod_done;
    logic [swr_pkg::IDX_W-1:0]  w_rank;
    logic [swr_pkg::CNT_W-1:0]  w_unused;
    logic [swr_pkg::CNT_W-1:0]  w_dc_inc;
    logic                       w_run_last;
    logic                       w_out_free;
    logic                       w_load_out;
    logic                       w_clear;

    // Effective counts: element_count into 1..MAX, sample_count into 1..n.
    always_comb begin
        if (r_elem == '0) begin
            w_n = swr_pkg::CNT_W'(1);
        end else if (r_elem > swr_pkg::CFG_W'(N)) begin
            w_n = swr_pkg::CNT_W'(N);
        end else begin
            w_n = swr_pkg::CNT_W'(r_elem);
        end
        if (r_samp == '0) begin
            w_s = swr_pkg::CNT_W'(1);
        end else if (swr_pkg::CNT_W'(r_samp) > w_n) begin
            w_s = w_n;
        end else begin
            w_s = swr_pkg::CNT_W'(r_samp);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem <= swr_pkg::ELEMENT_COUNT_RESET;
            r_samp <= swr_pkg::SAMPLE_COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swr_pkg::REG_ELEMENT_COUNT: r_elem <= i_cfg_data;
                swr_pkg::REG_SAMPLE_COUNT:  r_samp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cell chain: one used bit per cell, token handed on every cycle.
    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < N; g++) begin : g_cell
        swr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_limit (w_n),
            .i_clear (w_clear),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_end = w_tok[N];

    // No free slot below n after a register change: restart the run with all n free.
    assign w_unused = (w_end.val == '0) ? w_n : w_end.val;

    swr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_count_done),
        .i_dividend (r_word),
        .i_divisor  (w_unused),
        .o_done     (w_mod_done),
        .o_rem      (w_rank)
    );

    assign w_dc_inc   = r_dc + swr_pkg::CNT_W'(1);
    assign w_run_last = (w_dc_inc >= w_s);
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swr_pkg::ST_IDLE:   if (i_s_axis_tvalid) n_state = swr_pkg::ST_COUNT;
            swr_pkg::ST_COUNT:  if (w_end.valid)     n_state = swr_pkg::ST_MOD;
            swr_pkg::ST_MOD:    if (w_mod_done)      n_state = swr_pkg::ST_SELECT;
            swr_pkg::ST_SELECT: if (w_end.valid)     n_state = swr_pkg::ST_EMIT;
            swr_pkg::ST_EMIT:   if (w_out_free)      n_state = swr_pkg::ST_IDLE;
            default:            n_state = swr_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_axis_tready = (r_state == swr_pkg::ST_IDLE);
        w_accept        = o_s_axis_tready && i_s_axis_tvalid;
        w_count_done    = (r_state == swr_pkg::ST_COUNT) && w_end.valid;
        w_sel_done      = (r_state == swr_pkg::ST_SELECT) && w_end.valid;
        w_load_out      = (r_state == swr_pkg::ST_EMIT) && w_out_free;
        w_clear         = (w_accept && (i_s_axis_tuser || (r_dc >= w_s)))
                          || (w_count_done && (w_end.val == '0))
                          || (w_sel_done && w_run_last);

        n_inj = '0;
        if (w_accept) begin
            n_inj.valid = 1'b1;
        end else if ((r_state == swr_pkg::ST_MOD) && w_mod_done) begin
            n_inj.valid     = 1'b1;
            n_inj.is_select = 1'b1;
            n_inj.val       = swr_pkg::CNT_W'(w_rank);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swr_pkg::ST_IDLE;
            r_dc        <= '0;
            r_inj.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= n_inj;
            if (w_accept) begin
                r_word <= i_s_axis_tdata[swr_pkg::WORD_W-1:0];
            end
            // Mark the draw; drop the count whenever the map clears.
            if (w_clear) begin
                r_dc <= '0;
            end else if (w_sel_done) begin
                r_dc <= w_dc_inc;
            end
            if (w_sel_done) begin
                r_pick <= w_end.pick;
                r_last <= w_run_last;
            end
            // Hold the result until taken.
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_out_index <= r_pick;
                r_out_last  <= r_last;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8 - swr_pkg::IDX_W){1'b0}}, r_out_index};
    assign o_m_axis_tlast  = r_out_last;

    `ASSERT_NOW(a_sel_found, w_sel_done, w_end.found, "select pass found no free slot")
    `ASSERT_NOW(a_count_range, w_count_done, w_end.val <= w_n, "free count above element count")
    `ASSERT_NOW(a_rank_range, w_mod_done, swr_pkg::CNT_W'(w_rank) < w_unused, "rank not below free count")
    `ASSERT_NEXT(a_last_clears, w_sel_done && w_run_last, r_dc == '0, "draw count not cleared at run end")

endmodule
